FILE: hdl/slot_role_signal_tracker_defines.svh
// Assertion macros used by the checker file of the slot role tracker.
`ifndef SLOT_ROLE_SIGNAL_TRACKER_DEFINES_SVH
`define SLOT_ROLE_SIGNAL_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SRST_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SRST_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/srst_pkg.sv
// Types, constants and arithmetic helpers of the slot role tracker.
package srst_pkg;

    localparam int TsBits     = 48;
    localparam int SampleBits = 12;
    localparam int CfoBits    = 20;
    localparam int DiffBits   = CfoBits + 1;

    // Slot arithmetic: rounded slots = floor((gap + RoundBias) / SlotUs).
    localparam int SlotUs       = 625;
    localparam int RoundBias    = 312;
    localparam int HalfSlotUs   = 313;
    localparam int ChunkBits    = 8;
    localparam int NumChunks    = (TsBits + ChunkBits - 1) / ChunkBits;
    // Holds the folded residue sum for stamps up to 64 bits.
    localparam int SumBits      = 21;
    localparam int RecipShift   = 30;
    localparam int QuotBits     = 2 * SumBits - RecipShift;
    localparam int ResBits      = 10;
    localparam longint unsigned SlotRecip =
        ((64'd1 << RecipShift) + SlotUs - 1) / SlotUs;

    // Averaging step avg' = floor((4*avg + x + 2) / 5), done in CfoBits wide.
    localparam int BlendW = CfoBits;
    localparam int BlendU = BlendW + 3;
    localparam int BlendK = BlendU + 2;
    localparam longint unsigned BlendRecip = ((64'd1 << BlendK) + 4) / 5;
    localparam longint unsigned BlendOff   = 5 * (64'd1 << (BlendW - 1));

    typedef enum logic [1:0] {
        ROLE_CENTRAL    = 2'd0,
        ROLE_PERIPHERAL = 2'd1,
        ROLE_UNRESOLVED = 2'd2
    } role_t;

    typedef struct packed {
        logic signed [SampleBits-1:0] rssi;
        logic signed [SampleBits-1:0] snr;
        logic signed [CfoBits-1:0]    cfo;
    } sample_t;

    typedef struct packed {
        sample_t            smp;
        logic               first;
        logic               backward;
        logic [TsBits-1:0]  gap;
    } gap_word_t;

    typedef struct packed {
        sample_t smp;
        role_t   role;
    } role_word_t;

    typedef struct packed {
        role_t                        role;
        logic signed [SampleBits-1:0] rssi_all;
        logic signed [SampleBits-1:0] snr_all;
        logic signed [SampleBits-1:0] rssi_role;
        logic signed [SampleBits-1:0] snr_role;
        logic signed [CfoBits-1:0]    cfo_role;
        logic signed [CfoBits-1:0]    cfo_master;
        logic signed [CfoBits-1:0]    cfo_slave;
        logic                         both;
    } avg_word_t;

    // Weight of byte idx of a value, reduced modulo one slot.
    function automatic logic [SumBits-1:0] chunk_weight(input int idx);
        int w;
        w = 1;
        for (int j = 0; j < NumChunks; j++) begin
            if (j < idx) begin
                w = (w * (2 ** ChunkBits)) % SlotUs;
            end
        end
        return SumBits'(w);
    endfunction

    function automatic logic signed [CfoBits-1:0] widen(input logic signed [SampleBits-1:0] x);
        return {{(CfoBits - SampleBits){x[SampleBits-1]}}, x};
    endfunction

    // One averaging step, rounding an exact half upward. The offset keeps the
    // dividend positive so the divide by five is a reciprocal multiply.
    function automatic logic signed [CfoBits-1:0] blend(
        input logic signed [CfoBits-1:0] avg,
        input logic signed [CfoBits-1:0] x
    );
        logic signed [BlendU-1:0] s;
        logic [BlendU-1:0]        u;
        logic [2*BlendU-1:0]      prod;
        logic [BlendW:0]          q;
        s    = {{1{avg[CfoBits-1]}}, avg, 2'b00} + {{3{x[CfoBits-1]}}, x};
        u    = $unsigned(s) + BlendU'(BlendOff + 2);
        prod = {{BlendU{1'b0}}, u} * (2 * BlendU)'(BlendRecip);
        q    = prod[2*BlendU-1:BlendK];
        return CfoBits'(q - (BlendW + 1)'(64'd1 << (BlendW - 1)));
    endfunction

endpackage

FILE: hdl/srst_gap_stage.sv
// Input register stage: arrival gap against the previous timestamp.
module srst_gap_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [srst_pkg::TsBits-1:0] timestamp_us,
    input  srst_pkg::sample_t           smp,
    output logic                        dn_valid,
    output srst_pkg::gap_word_t         dn_word,
    input  logic                        dn_ready
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [srst_pkg::TsBits-1:0] prev_ts_reg;
    logic                        ref_set_reg;
    srst_pkg::gap_word_t         word_reg;
    srst_pkg::gap_word_t         word_next;
    logic [srst_pkg::TsBits:0]   diff;
    logic                        load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign diff     = {1'b0, timestamp_us} - {1'b0, prev_ts_reg};

    always_comb
    begin
        valid_next         = up_ready ? up_valid : valid_reg;
        word_next.smp      = smp;
        word_next.first    = !ref_set_reg;
        // A borrow or a zero difference means the stamp did not move forward.
        word_next.backward = ref_set_reg &&
                             (diff[srst_pkg::TsBits] || (diff[srst_pkg::TsBits-1:0] == '0));
        word_next.gap      = diff[srst_pkg::TsBits-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            prev_ts_reg <= '0;
            ref_set_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                prev_ts_reg <= timestamp_us;
                ref_set_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

FILE: hdl/srst_slot_parity.sv
// Slot count parity: rounded gap in slots, its parity and the packet role.
module srst_slot_parity (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  srst_pkg::gap_word_t   up_word,
    output logic                  dn_valid,
    output srst_pkg::role_word_t  dn_word,
    input  logic                  dn_ready
);

    localparam int PadBits = srst_pkg::NumChunks * srst_pkg::ChunkBits;

    typedef struct packed {
        srst_pkg::sample_t             smp;
        logic                          first;
        logic                          backward;
        logic                          near_gap;
        logic                          low_bit;
        logic [srst_pkg::SumBits-1:0]  sum;
    } fold_t;

    typedef struct packed {
        fold_t                         fold;
        logic [srst_pkg::QuotBits-1:0] quot;
    } quot_t;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  v1_next, v2_next, v3_next;
    logic                  ready1, ready2, ready3;
    fold_t                 s1_reg, s1_next;
    quot_t                 s2_reg, s2_next;
    srst_pkg::role_word_t  s3_reg, s3_next;
    logic                  parity_reg, parity_next;

    logic [srst_pkg::TsBits:0]       biased;
    logic [PadBits-1:0]              halved;
    logic [2*srst_pkg::SumBits-1:0]  prod;
    logic [srst_pkg::SumBits-1:0]    rem_full;
    logic [srst_pkg::ResBits:0]      twice_rem;
    logic                            slot_odd;

    assign ready3   = !v3_reg || dn_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign up_ready = ready1;

    // Fold the halved biased gap byte by byte into a small value with the
    // same residue modulo one slot; its low bit is kept aside.
    always_comb
    begin
        biased = {1'b0, up_word.gap} + (srst_pkg::TsBits + 1)'(srst_pkg::RoundBias);
        halved = PadBits'(biased[srst_pkg::TsBits:1]);
        s1_next.smp      = up_word.smp;
        s1_next.first    = up_word.first;
        s1_next.backward = up_word.backward;
        s1_next.near_gap = up_word.gap < srst_pkg::TsBits'(srst_pkg::HalfSlotUs);
        s1_next.low_bit  = biased[0];
        s1_next.sum      = '0;
        for (int i = 0; i < srst_pkg::NumChunks; i++)
        begin
            s1_next.sum = s1_next.sum
                + srst_pkg::SumBits'(halved[i*srst_pkg::ChunkBits +: srst_pkg::ChunkBits])
                * srst_pkg::chunk_weight(i);
        end
    end

    always_comb
    begin
        prod = {{srst_pkg::SumBits{1'b0}}, s1_reg.sum}
             * (2 * srst_pkg::SumBits)'(srst_pkg::SlotRecip);
        s2_next.fold = s1_reg;
        s2_next.quot = prod[srst_pkg::RecipShift +: srst_pkg::QuotBits];
    end

    always_comb
    begin
        rem_full  = s2_reg.fold.sum
                  - srst_pkg::SumBits'(s2_reg.quot) * srst_pkg::SumBits'(srst_pkg::SlotUs);
        twice_rem = {rem_full[srst_pkg::ResBits-1:0], s2_reg.fold.low_bit};
        // Odd slot count when the residue modulo two slots is in the upper slot;
        // a gap that rounds to zero slots still counts as one.
        slot_odd  = s2_reg.fold.near_gap ||
                    (twice_rem >= (srst_pkg::ResBits + 1)'(srst_pkg::SlotUs));
        s3_next.smp = s2_reg.fold.smp;
        parity_next = parity_reg;
        priority if (s2_reg.fold.first)
        begin
            parity_next  = 1'b0;
            s3_next.role = srst_pkg::ROLE_CENTRAL;
        end
        else if (s2_reg.fold.backward)
        begin
            s3_next.role = srst_pkg::ROLE_UNRESOLVED;
        end
        else
        begin
            parity_next  = parity_reg ^ slot_odd;
            s3_next.role = parity_next ? srst_pkg::ROLE_PERIPHERAL : srst_pkg::ROLE_CENTRAL;
        end
    end

    always_comb
    begin
        v1_next = ready1 ? up_valid : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            if (ready3 && v2_reg)
            begin
                parity_reg <= parity_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (ready2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (ready3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign dn_valid = v3_reg;
    assign dn_word  = s3_reg;

endmodule

FILE: hdl/srst_avg_unit.sv
// Running averages: aggregate RSSI and SNR, per-role RSSI, SNR and CFO.
module srst_avg_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  srst_pkg::role_word_t  up_word,
    output logic                  dn_valid,
    output srst_pkg::avg_word_t   dn_word,
    input  logic                  dn_ready
);

    localparam int Sb = srst_pkg::SampleBits;
    localparam int Cb = srst_pkg::CfoBits;

    logic                 valid_reg, valid_next;
    logic                 load;
    srst_pkg::avg_word_t  word_reg, word_next;

    logic signed [Sb-1:0] agg_rssi_reg, agg_rssi_next;
    logic signed [Sb-1:0] agg_snr_reg, agg_snr_next;
    logic signed [Sb-1:0] m_rssi_reg, m_rssi_next, s_rssi_reg, s_rssi_next;
    logic signed [Sb-1:0] m_snr_reg, m_snr_next, s_snr_reg, s_snr_next;
    logic signed [Cb-1:0] m_cfo_reg, m_cfo_next, s_cfo_reg, s_cfo_next;
    logic                 m_has_reg, m_has_next, s_has_reg, s_has_next;

    logic                 known;
    logic                 is_slave;
    logic                 sel_has;
    logic signed [Sb-1:0] sel_rssi, sel_snr, upd_rssi, upd_snr;
    logic signed [Cb-1:0] sel_cfo, upd_cfo;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        known    = (up_word.role != srst_pkg::ROLE_UNRESOLVED);
        is_slave = (up_word.role == srst_pkg::ROLE_PERIPHERAL);
        sel_has  = is_slave ? s_has_reg  : m_has_reg;
        sel_rssi = is_slave ? s_rssi_reg : m_rssi_reg;
        sel_snr  = is_slave ? s_snr_reg  : m_snr_reg;
        sel_cfo  = is_slave ? s_cfo_reg  : m_cfo_reg;

        agg_rssi_next = Sb'(srst_pkg::blend(srst_pkg::widen(agg_rssi_reg),
                                            srst_pkg::widen(up_word.smp.rssi)));
        agg_snr_next  = Sb'(srst_pkg::blend(srst_pkg::widen(agg_snr_reg),
                                            srst_pkg::widen(up_word.smp.snr)));

        // The first sample of a role seeds its averages directly.
        upd_rssi = sel_has ? Sb'(srst_pkg::blend(srst_pkg::widen(sel_rssi),
                                                 srst_pkg::widen(up_word.smp.rssi)))
                           : up_word.smp.rssi;
        upd_snr  = sel_has ? Sb'(srst_pkg::blend(srst_pkg::widen(sel_snr),
                                                 srst_pkg::widen(up_word.smp.snr)))
                           : up_word.smp.snr;
        upd_cfo  = sel_has ? srst_pkg::blend(sel_cfo, up_word.smp.cfo) : up_word.smp.cfo;

        m_rssi_next = (known && !is_slave) ? upd_rssi : m_rssi_reg;
        m_snr_next  = (known && !is_slave) ? upd_snr  : m_snr_reg;
        m_cfo_next  = (known && !is_slave) ? upd_cfo  : m_cfo_reg;
        m_has_next  = m_has_reg || (known && !is_slave);
        s_rssi_next = (known && is_slave) ? upd_rssi : s_rssi_reg;
        s_snr_next  = (known && is_slave) ? upd_snr  : s_snr_reg;
        s_cfo_next  = (known && is_slave) ? upd_cfo  : s_cfo_reg;
        s_has_next  = s_has_reg || (known && is_slave);

        word_next.role       = up_word.role;
        word_next.rssi_all   = agg_rssi_next;
        word_next.snr_all    = agg_snr_next;
        word_next.rssi_role  = known ? upd_rssi : '0;
        word_next.snr_role   = known ? upd_snr  : '0;
        word_next.cfo_role   = known ? upd_cfo  : '0;
        word_next.cfo_master = m_cfo_next;
        word_next.cfo_slave  = s_cfo_next;
        word_next.both       = m_has_next && s_has_next;

        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            agg_rssi_reg <= '0;
            agg_snr_reg  <= '0;
            m_rssi_reg   <= '0;
            m_snr_reg    <= '0;
            m_cfo_reg    <= '0;
            m_has_reg    <= 1'b0;
            s_rssi_reg   <= '0;
            s_snr_reg    <= '0;
            s_cfo_reg    <= '0;
            s_has_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                agg_rssi_reg <= agg_rssi_next;
                agg_snr_reg  <= agg_snr_next;
                m_rssi_reg   <= m_rssi_next;
                m_snr_reg    <= m_snr_next;
                m_cfo_reg    <= m_cfo_next;
                m_has_reg    <= m_has_next;
                s_rssi_reg   <= s_rssi_next;
                s_snr_reg    <= s_snr_next;
                s_cfo_reg    <= s_cfo_next;
                s_has_reg    <= s_has_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

FILE: hdl/slot_role_signal_tracker.sv
// Top level of the slot role tracker: pipeline stages and the result register.
//
// Input channel: in_valid/in_stall with timestamp_us, rssi, snr and cfo, one
// received packet per word. Output channel: out_valid/out_stall with the role
// and the averages after that packet, one result word per input word.
// A word moves when valid is high and stall is low at a rising clock edge.
//
// One packet is taken every cycle unless the pipeline is full behind a stalled
// receiver; the feedback paths (slot parity, running averages) each close
// within a single stage, and the divide by the slot length is spread over
// three stages, the last of which loads the parity register.
//
// Every stage carries its own valid bit and fills whenever the stage after it
// is empty or moving, so input words are still taken while a result waits on
// a stalled receiver, until all six registers hold words.
//
// Reset (rst_n low, asynchronous) empties the pipeline and clears the slot
// reference, the previous timestamp, the parity and all averages to zero.
module slot_role_signal_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [srst_pkg::TsBits-1:0]          timestamp_us,
    input  logic signed [srst_pkg::SampleBits-1:0] rssi,
    input  logic signed [srst_pkg::SampleBits-1:0] snr,
    input  logic signed [srst_pkg::CfoBits-1:0]    cfo,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           role,
    output logic signed [srst_pkg::SampleBits-1:0] avg_rssi_all,
    output logic signed [srst_pkg::SampleBits-1:0] avg_snr_all,
    output logic signed [srst_pkg::SampleBits-1:0] avg_rssi_role,
    output logic signed [srst_pkg::SampleBits-1:0] avg_snr_role,
    output logic signed [srst_pkg::CfoBits-1:0]    avg_cfo_role,
    output logic signed [srst_pkg::DiffBits-1:0]   cfo_diff,
    output logic                                 cfo_diff_valid
);

    srst_pkg::sample_t     smp;
    logic                  in_ready;
    logic                  gap_valid, gap_ready;
    srst_pkg::gap_word_t   gap_word;
    logic                  role_valid, role_ready;
    srst_pkg::role_word_t  role_word;
    logic                  avg_valid, avg_ready;
    srst_pkg::avg_word_t   avg_word;

    logic                                 out_valid_reg, out_valid_next;
    srst_pkg::avg_word_t                  res_reg;
    logic signed [srst_pkg::DiffBits-1:0] diff_reg, diff_next;

    assign smp.rssi = rssi;
    assign smp.snr  = snr;
    assign smp.cfo  = cfo;
    assign in_stall = !in_ready;

    srst_gap_stage u_gap (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (in_valid),
        .up_ready     (in_ready),
        .timestamp_us (timestamp_us),
        .smp          (smp),
        .dn_valid     (gap_valid),
        .dn_word      (gap_word),
        .dn_ready     (gap_ready)
    );

    srst_slot_parity u_slot (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (gap_valid),
        .up_ready (gap_ready),
        .up_word  (gap_word),
        .dn_valid (role_valid),
        .dn_word  (role_word),
        .dn_ready (role_ready)
    );

    srst_avg_unit u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (role_valid),
        .up_ready (role_ready),
        .up_word  (role_word),
        .dn_valid (avg_valid),
        .dn_word  (avg_word),
        .dn_ready (avg_ready)
    );

    assign avg_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = avg_ready ? avg_valid : out_valid_reg;
        // Both roles stay seen once seen, so the difference is forced to zero only until then.
        diff_next = avg_word.both
                  ? ({avg_word.cfo_master[srst_pkg::CfoBits-1], avg_word.cfo_master}
                   - {avg_word.cfo_slave[srst_pkg::CfoBits-1], avg_word.cfo_slave})
                  : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_ready && avg_valid)
        begin
            res_reg  <= avg_word;
            diff_reg <= diff_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign role           = res_reg.role;
    assign avg_rssi_all   = res_reg.rssi_all;
    assign avg_snr_all    = res_reg.snr_all;
    assign avg_rssi_role  = res_reg.rssi_role;
    assign avg_snr_role   = res_reg.snr_role;
    assign avg_cfo_role   = res_reg.cfo_role;
    assign cfo_diff       = diff_reg;
    assign cfo_diff_valid = res_reg.both;

endmodule

FILE: hdl/srst_checker.sv
// Port-level checker of the slot role tracker and its bind to the top level.
`include "slot_role_signal_tracker_defines.svh"

module srst_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [1:0]                             role,
    input logic signed [srst_pkg::SampleBits-1:0] avg_rssi_role,
    input logic signed [srst_pkg::SampleBits-1:0] avg_snr_role,
    input logic signed [srst_pkg::CfoBits-1:0]    avg_cfo_role,
    input logic signed [srst_pkg::DiffBits-1:0]   cfo_diff,
    input logic                                   cfo_diff_valid
);

    // A stalled result word must hold.
    `SRST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(role) && $stable(cfo_diff), "result word changed while stalled")

    // The input side only stalls when a finished result is being held back.
    `SRST_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with result not held")

    // A packet of unknown role reports zero per-role averages.
    `SRST_ASSERT_IMPLY(a_unknown_zero, out_valid && (role == srst_pkg::ROLE_UNRESOLVED), (avg_rssi_role == '0) && (avg_snr_role == '0) && (avg_cfo_role == '0), "unknown role with nonzero role averages")

    // The difference reads zero until both roles have a sample.
    `SRST_ASSERT_IMPLY(a_diff_zero, out_valid && !cfo_diff_valid, cfo_diff == '0, "cfo difference nonzero before both roles seen")

    // Once both roles have a sample that stays true for every later result.
    `SRST_ASSERT_NEXT(a_diff_sticky, out_valid && cfo_diff_valid, !out_valid || cfo_diff_valid, "cfo difference valid dropped")

endmodule

bind slot_role_signal_tracker srst_checker u_srst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .role           (role),
    .avg_rssi_role  (avg_rssi_role),
    .avg_snr_role   (avg_snr_role),
    .avg_cfo_role   (avg_cfo_role),
    .cfo_diff       (cfo_diff),
    .cfo_diff_valid (cfo_diff_valid)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the slot role tracker: predictor, scoreboard and stimulus.
module tb_top;
    import srst_pkg::*;

    localparam int SLOT_LEN_US  = 625;
    localparam int HALF_SLOT_US = 313;

    typedef struct packed {
        role_t                        role;
        logic signed [SampleBits-1:0] rssi_all;
        logic signed [SampleBits-1:0] snr_all;
        logic signed [SampleBits-1:0] rssi_role;
        logic signed [SampleBits-1:0] snr_role;
        logic signed [CfoBits-1:0]    cfo_role;
        logic signed [DiffBits-1:0]   cfo_diff;
        logic                         diff_valid;
    } tracker_result_t;

    // Predicts the role and the running averages of each packet and checks them in order.
    class slot_role_checker;
        tracker_result_t   pending_results[$];
        logic [TsBits-1:0] last_stamp;
        bit                stamp_ref_set;
        bit                parity;
        int                agg_rssi;
        int                agg_snr;
        int                role_rssi[2];
        int                role_snr[2];
        int                role_cfo[2];
        bit                role_seen[2];
        int                cfo_gap;
        int                mismatches;
        int                checked;
        int                role_count[3];

        function new();
            last_stamp    = '0;
            stamp_ref_set = 0;
            parity        = 0;
            agg_rssi      = 0;
            agg_snr       = 0;
            cfo_gap       = 0;
            mismatches    = 0;
            checked       = 0;
            for (int i = 0; i < 2; i++) begin
                role_rssi[i] = 0;
                role_snr[i]  = 0;
                role_cfo[i]  = 0;
                role_seen[i] = 0;
            end
            for (int i = 0; i < 3; i++) begin
                role_count[i] = 0;
            end
        endfunction

        // round((4*avg + x) / 5) with an exact half going upward
        function int smooth(int avg, int x);
            longint n;
            longint q;
            n = 2 * (4 * longint'(avg) + longint'(x)) + 5;
            q = n / 10;
            if (n % 10 != 0 && n < 0) begin
                q--;
            end
            return int'(q);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void note_packet(logic [TsBits-1:0] stamp, int rssi_in, int snr_in, int cfo_in);
            tracker_result_t  want;
            longint unsigned  gap;
            longint unsigned  slots;
            role_t            r;
            int               k;
            if (!stamp_ref_set) begin
                stamp_ref_set = 1;
                parity        = 0;
                r             = ROLE_CENTRAL;
            end else if (stamp <= last_stamp) begin
                r = ROLE_UNRESOLVED;
            end else begin
                gap   = longint'(stamp) - longint'(last_stamp);
                slots = gap / SLOT_LEN_US;
                if (gap % SLOT_LEN_US >= HALF_SLOT_US) begin
                    slots++;
                end
                if (slots == 0) begin
                    slots = 1;
                end
                parity ^= slots[0];
                r = parity ? ROLE_PERIPHERAL : ROLE_CENTRAL;
            end
            last_stamp = stamp;

            agg_rssi = smooth(agg_rssi, rssi_in);
            agg_snr  = smooth(agg_snr, snr_in);

            want           = '0;
            want.role      = r;
            want.rssi_all  = SampleBits'(agg_rssi);
            want.snr_all   = SampleBits'(agg_snr);
            if (r != ROLE_UNRESOLVED) begin
                k = (r == ROLE_PERIPHERAL) ? 1 : 0;
                if (role_seen[k]) begin
                    role_rssi[k] = smooth(role_rssi[k], rssi_in);
                    role_snr[k]  = smooth(role_snr[k], snr_in);
                    role_cfo[k]  = smooth(role_cfo[k], cfo_in);
                end else begin
                    // A role's first sample seeds its averages directly.
                    role_rssi[k] = rssi_in;
                    role_snr[k]  = snr_in;
                    role_cfo[k]  = cfo_in;
                    role_seen[k] = 1;
                end
                want.rssi_role = SampleBits'(role_rssi[k]);
                want.snr_role  = SampleBits'(role_snr[k]);
                want.cfo_role  = CfoBits'(role_cfo[k]);
            end
            if (role_seen[0] && role_seen[1]) begin
                cfo_gap = role_cfo[0] - role_cfo[1];
            end
            want.cfo_diff   = DiffBits'(cfo_gap);
            want.diff_valid = role_seen[0] && role_seen[1];
            role_count[r]++;
            pending_results.push_back(want);
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
            end
        endtask

        task check_result(tracker_result_t got);
            tracker_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result word with no packet pending");
                return;
            end
            want = pending_results.pop_front();
            checked++;
            check_field("role", got.role, want.role);
            check_field("avg_rssi_all", got.rssi_all, want.rssi_all);
            check_field("avg_snr_all", got.snr_all, want.snr_all);
            check_field("avg_rssi_role", got.rssi_role, want.rssi_role);
            check_field("avg_snr_role", got.snr_role, want.snr_role);
            check_field("avg_cfo_role", got.cfo_role, want.cfo_role);
            check_field("cfo_diff", got.cfo_diff, want.cfo_diff);
            check_field("cfo_diff_valid", got.diff_valid, want.diff_valid);
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [TsBits-1:0]            timestamp_us;
    logic signed [SampleBits-1:0] rssi;
    logic signed [SampleBits-1:0] snr;
    logic signed [CfoBits-1:0]    cfo;
    logic                         out_valid;
    logic                         out_stall;
    logic [1:0]                   role;
    logic signed [SampleBits-1:0] avg_rssi_all;
    logic signed [SampleBits-1:0] avg_snr_all;
    logic signed [SampleBits-1:0] avg_rssi_role;
    logic signed [SampleBits-1:0] avg_snr_role;
    logic signed [CfoBits-1:0]    avg_cfo_role;
    logic signed [DiffBits-1:0]   cfo_diff;
    logic                         cfo_diff_valid;

    slot_role_checker  sb;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic [TsBits-1:0] ts_cursor;

    slot_role_signal_tracker u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .timestamp_us   (timestamp_us),
        .rssi           (rssi),
        .snr            (snr),
        .cfo            (cfo),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .role           (role),
        .avg_rssi_all   (avg_rssi_all),
        .avg_snr_all    (avg_snr_all),
        .avg_rssi_role  (avg_rssi_role),
        .avg_snr_role   (avg_snr_role),
        .avg_cfo_role   (avg_cfo_role),
        .cfo_diff       (cfo_diff),
        .cfo_diff_valid (cfo_diff_valid)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: check every accepted word, then pick the next stall.
    always @(posedge clk)
    begin : result_side
        tracker_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.role       = role_t'(role);
            got.rssi_all   = avg_rssi_all;
            got.snr_all    = avg_snr_all;
            got.rssi_role  = avg_rssi_role;
            got.snr_role   = avg_snr_role;
            got.cfo_role   = avg_cfo_role;
            got.cfo_diff   = cfo_diff;
            got.diff_valid = cfo_diff_valid;
            sb.check_result(got);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offers one packet word and holds it until the block takes it.
    task automatic send_packet(input logic [TsBits-1:0] stamp, input logic [SampleBits-1:0] r,
                               input logic [SampleBits-1:0] s, input logic [CfoBits-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        timestamp_us <= stamp;
        rssi         <= r;
        snr          <= s;
        cfo          <= c;
        do begin
            @(posedge clk);
        end while (in_stall);
        sb.note_packet(stamp, $signed(r), $signed(s), $signed(c));
    endtask

    // Mostly full-range random values, now and then a corner of the range.
    function automatic logic [31:0] pick_value(int bits);
        logic [31:0] top;
        top = 32'd1 << (bits - 1);
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: return top;
                1: return top - 1;
                2: return '0;
                default: return (top << 1) - 1;
            endcase
        end
        return $urandom & ((top << 1) - 1);
    endfunction

    // Timestamps mostly follow a slot grid with jitter; the rest are short steps,
    // repeats, steps backward, rounding boundaries and arbitrary jumps.
    task automatic send_random_packets(input int count);
        int                pick;
        int                gap;
        logic [TsBits-1:0] stamp;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                gap   = int'($urandom_range(4, 1)) * SLOT_LEN_US - 330 + int'($urandom_range(660));
                stamp = ts_cursor + TsBits'(gap);
            end else if (pick < 72) begin
                stamp = ts_cursor + TsBits'($urandom_range(320, 1));
            end else if (pick < 80) begin
                gap   = int'($urandom_range(3)) * SLOT_LEN_US + 312 + int'($urandom_range(1));
                stamp = ts_cursor + TsBits'(gap);
            end else if (pick < 88) begin
                stamp = ts_cursor;
            end else if (pick < 94) begin
                stamp = ts_cursor - TsBits'($urandom_range(2000, 1));
            end else begin
                stamp = TsBits'({$urandom, $urandom});
            end
            ts_cursor = stamp;
            send_packet(stamp, SampleBits'(pick_value(SampleBits)),
                        SampleBits'(pick_value(SampleBits)), CfoBits'(pick_value(CfoBits)));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        timestamp_us   <= '0;
        rssi           <= '0;
        snr            <= '0;
        cfo            <= '0;
        out_stall      <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb             = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: first packet with extreme samples, repeated and
        // backward stamps, gaps on both sides of the first two rounding points, a jump
        // to the top of the stamp range and a wrap back to zero.
        send_packet(48'd1000, 12'h7FF, 12'h800, 20'h7FFFF);
        send_packet(48'd1000, 12'h000, 12'h000, 20'h00000);
        send_packet(48'd999, 12'hFFF, 12'hFFF, 20'hFFFFF);
        send_packet(48'd1000, 12'h800, 12'h7FF, 20'h80000);
        send_packet(48'd1312, 12'h7FF, 12'h7FF, 20'h7FFFF);
        send_packet(48'd1625, 12'h800, 12'h800, 20'h80000);
        send_packet(48'd2562, 12'h123, 12'hEDC, 20'h12345);
        send_packet(48'd3500, 12'h800, 12'h7FF, 20'h7FFFF);
        send_packet(48'd4125, 12'h7FF, 12'h800, 20'h80000);
        send_packet(48'd5375, 12'h001, 12'hFFF, 20'h00001);
        send_packet(48'hFFFF_FFFF_FFFF, 12'h7FF, 12'h7FF, 20'h7FFFF);
        send_packet(48'd0, 12'h800, 12'h800, 20'h80000);
        send_packet(48'd0, 12'h7FF, 12'h800, 20'h7FFFF);
        ts_cursor = '0;
        for (int i = 0; i < 8; i++) begin
            ts_cursor = ts_cursor + TsBits'(SLOT_LEN_US);
            send_packet(ts_cursor, (i % 2) ? 12'h7FF : 12'h800, (i % 2) ? 12'h800 : 12'h7FF,
                        (i % 2) ? 20'h7FFFF : 20'h80000);
        end

        send_random_packets(460);
        send_idle_pct  = 81;
        recv_stall_pct = 0;
        send_random_packets(460);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        send_random_packets(460);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_random_packets(460);
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Checked %0d result words: %0d master, %0d slave, %0d unknown packets.",
                 sb.checked, sb.role_count[ROLE_CENTRAL], sb.role_count[ROLE_PERIPHERAL],
                 sb.role_count[ROLE_UNRESOLVED]);
        $display("Traffic ran free, with a sparse sender, a stalling receiver and both idling.");
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial
    begin
        #2400000;
        $display("Timed out with %0d result words outstanding.", sb.pending_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
